@@ rtl/bgal_pkg.sv @@
// bgal_pkg: shared types and constants for the button gesture and light block
// depends on nothing
package bgal_pkg;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_BLUE_SHORT   = 3'd1,
    EV_BLUE_LONG    = 3'd2,
    EV_ORANGE_SHORT = 3'd3,
    EV_ORANGE_LONG  = 3'd4,
    EV_BLUE_DUO     = 3'd5,
    EV_ORANGE_DUO   = 3'd6
  } event_t;

  typedef enum logic {
    OP_STATUS  = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_ACK_BLINK  = 2'd1
  } reg_index_t;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [15:0] ACK_BLINK_RESET  = 16'd100;
  localparam logic [7:0]  DEFAULT_LEVEL    = 8'd127;
  localparam logic signed [7:0] IR_MODE_MAX = -8'sd2;
  localparam int unsigned BLUE_BIT   = 0;
  localparam int unsigned ORANGE_BIT = 1;

  // button state seen by the light logic
  typedef struct packed {
    logic        blue_held;
    logic        orange_held;
    logic [31:0] blue_start;
    logic [31:0] orange_start;
  } press_t;

endpackage

@@ rtl/bgal_gesture.sv @@
// bgal_gesture: button press state and release classification
// depends on bgal_pkg
module bgal_gesture (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  logic [31:0]          now_ms,
  input  logic [1:0]           status_bits,
  input  logic [15:0]          long_press_ms,
  output bgal_pkg::event_t     event_code,
  output bgal_pkg::press_t     press
);

  bgal_pkg::press_t press_next;
  logic swallow_blue;
  logic swallow_orange;
  logic swallow_blue_next;
  logic swallow_orange_next;
  logic blue_now;
  logic orange_now;
  logic blue_rel;
  logic orange_rel;
  logic [31:0] blue_dur;
  logic [31:0] orange_dur;

  always_comb begin
    blue_now   = ~status_bits[bgal_pkg::BLUE_BIT];
    orange_now = ~status_bits[bgal_pkg::ORANGE_BIT];
    blue_rel   = press.blue_held & ~blue_now;
    orange_rel = press.orange_held & ~orange_now;
    blue_dur   = now_ms - press.blue_start;
    orange_dur = now_ms - press.orange_start;

    press_next              = press;
    press_next.blue_held    = blue_now;
    press_next.orange_held  = orange_now;
    if (blue_now && !press.blue_held) begin
      press_next.blue_start = now_ms;
    end
    if (orange_now && !press.orange_held) begin
      press_next.orange_start = now_ms;
    end

    event_code          = bgal_pkg::EV_NONE;
    swallow_blue_next   = swallow_blue;
    swallow_orange_next = swallow_orange;
    if (blue_rel && swallow_blue) begin
      swallow_blue_next = 1'b0;
    end
    if (blue_rel && !swallow_blue) begin
      if (orange_now) begin
        swallow_orange_next = 1'b1;
        event_code          = bgal_pkg::EV_BLUE_DUO;
      end else if (blue_dur < {16'd0, long_press_ms}) begin
        event_code = bgal_pkg::EV_BLUE_SHORT;
      end else begin
        event_code = bgal_pkg::EV_BLUE_LONG;
      end
    end else if (orange_rel) begin
      if (swallow_orange) begin
        swallow_orange_next = 1'b0;
      end else if (blue_now) begin
        swallow_blue_next = 1'b1;
        event_code        = bgal_pkg::EV_ORANGE_DUO;
      end else if (orange_dur < {16'd0, long_press_ms}) begin
        event_code = bgal_pkg::EV_ORANGE_SHORT;
      end else begin
        event_code = bgal_pkg::EV_ORANGE_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press          <= '0;
      swallow_blue   <= 1'b0;
      swallow_orange <= 1'b0;
    end else if (update) begin
      press          <= press_next;
      swallow_blue   <= swallow_blue_next;
      swallow_orange <= swallow_orange_next;
    end
  end

endmodule

@@ rtl/bgal_lights.sv @@
// bgal_lights: blue, orange and infrared drive levels with acknowledge blanking
// depends on bgal_pkg
module bgal_lights (
  input  logic [31:0]        now_ms,
  input  logic               connected,
  input  logic [7:0]         brightness,
  input  logic signed [7:0]  duo_mode,
  input  logic signed [7:0]  solo_mode,
  input  logic [7:0]         infrared_request,
  input  logic [15:0]        long_press_ms,
  input  logic [15:0]        ack_blink_ms,
  input  bgal_pkg::press_t   press,
  output logic [7:0]         blue_level,
  output logic [7:0]         orange_level,
  output logic [7:0]         infrared_level
);

  logic [7:0]  def_level;
  logic [16:0] window_end;
  logic [31:0] blue_dur;
  logic [31:0] orange_dur;
  logic        blue_blink;
  logic        orange_blink;

  always_comb begin
    def_level  = connected ? brightness : bgal_pkg::DEFAULT_LEVEL;
    window_end = {1'b0, ack_blink_ms} + {1'b0, long_press_ms};
    blue_dur   = now_ms - press.blue_start;
    orange_dur = now_ms - press.orange_start;
    // blank right after the press and again just past the long-press mark
    blue_blink = (blue_dur < {16'd0, ack_blink_ms})
              || ((blue_dur < {15'd0, window_end}) && (blue_dur > {16'd0, long_press_ms}));
    orange_blink = (orange_dur < {16'd0, ack_blink_ms})
              || ((orange_dur < {15'd0, window_end}) && (orange_dur > {16'd0, long_press_ms}));

    blue_level   = def_level;
    orange_level = def_level;
    if (duo_mode > 8'sd0 || solo_mode > 8'sd0) begin
      blue_level = '0;
    end
    if (duo_mode < 8'sd0 || solo_mode < 8'sd0) begin
      orange_level = '0;
    end
    if (press.orange_held) begin
      if (orange_blink) begin
        orange_level = '0;
      end
      blue_level = '0;
    end
    if (press.blue_held) begin
      if (blue_blink) begin
        blue_level = '0;
      end
      orange_level = '0;
    end
    // both held: the later press gets its light back
    if (press.blue_held && press.orange_held) begin
      if (press.blue_start < press.orange_start) begin
        orange_level = def_level;
      end else begin
        blue_level = def_level;
      end
    end
    infrared_level = (duo_mode <= bgal_pkg::IR_MODE_MAX) ? infrared_request : '0;
  end

endmodule

@@ rtl/button_gesture_and_ack_lights.sv @@
// button_gesture_and_ack_lights: top level, input register, result register
// press state updates are registered and seen by the next request
// throughput: one request per cycle while out_ready does not stall the output
// reset: long press 1000 ms, blink 100 ms, no button held, no release swallowed
// depends on bgal_pkg, bgal_gesture, bgal_lights
module button_gesture_and_ack_lights (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [31:0]        now_ms,
  input  logic [1:0]         status_bits,
  input  logic               connected,
  input  logic [7:0]         brightness,
  input  logic signed [7:0]  duo_mode,
  input  logic signed [7:0]  solo_mode,
  input  logic [7:0]         infrared_request,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_code,
  output logic [7:0]         blue_level,
  output logic [7:0]         orange_level,
  output logic [7:0]         infrared_level
);

  logic [15:0] long_press_ms;
  logic [15:0] ack_blink_ms;

  logic               s1_valid;
  bgal_pkg::op_t      s1_op;
  logic [31:0]        s1_now;
  logic [1:0]         s1_bits;
  logic               s1_conn;
  logic [7:0]         s1_bright;
  logic signed [7:0]  s1_duo;
  logic signed [7:0]  s1_solo;
  logic [7:0]         s1_ir;

  logic               advance;
  logic               status_update;
  bgal_pkg::event_t   ev;
  bgal_pkg::press_t   press;
  logic [7:0]         blue_c;
  logic [7:0]         orange_c;
  logic [7:0]         ir_c;

  assign advance       = s1_valid && (!out_valid || out_ready);
  assign in_ready      = !s1_valid || advance;
  assign status_update = advance && (s1_op == bgal_pkg::OP_STATUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= bgal_pkg::LONG_PRESS_RESET;
      ack_blink_ms  <= bgal_pkg::ACK_BLINK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bgal_pkg::REG_LONG_PRESS: long_press_ms <= cfg_data;
        bgal_pkg::REG_ACK_BLINK:  ack_blink_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op     <= bgal_pkg::op_t'(operation);
      s1_now    <= now_ms;
      s1_bits   <= status_bits;
      s1_conn   <= connected;
      s1_bright <= brightness;
      s1_duo    <= duo_mode;
      s1_solo   <= solo_mode;
      s1_ir     <= infrared_request;
    end
  end

  bgal_gesture u_gesture (
    .clk           (clk),
    .rst           (rst),
    .update        (status_update),
    .now_ms        (s1_now),
    .status_bits   (s1_bits),
    .long_press_ms (long_press_ms),
    .event_code    (ev),
    .press         (press)
  );

  bgal_lights u_lights (
    .now_ms           (s1_now),
    .connected        (s1_conn),
    .brightness       (s1_bright),
    .duo_mode         (s1_duo),
    .solo_mode        (s1_solo),
    .infrared_request (s1_ir),
    .long_press_ms    (long_press_ms),
    .ack_blink_ms     (ack_blink_ms),
    .press            (press),
    .blue_level       (blue_c),
    .orange_level     (orange_c),
    .infrared_level   (ir_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_op == bgal_pkg::OP_STATUS) begin
        event_code     <= ev;
        blue_level     <= '0;
        orange_level   <= '0;
        infrared_level <= '0;
      end else begin
        event_code     <= bgal_pkg::EV_NONE;
        blue_level     <= blue_c;
        orange_level   <= orange_c;
        infrared_level <= ir_c;
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for button_gesture_and_ack_lights
// a tracker class predicts every result and checks them in order; tasks drive the requests
// depends on bgal_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;
  import bgal_pkg::*;

  localparam logic [1:0] FIRST_UNUSED_REG = 2'd2;
  localparam logic [1:0] LAST_UNUSED_REG  = 2'd3;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 144;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    op_t                op;
    logic [31:0]        now;
    logic [1:0]         bits;
    logic               conn;
    logic [7:0]         bright;
    logic signed [7:0]  duo;
    logic signed [7:0]  solo;
    logic [7:0]         ir;
  } request_t;

  typedef struct {
    event_t     ev;
    logic [7:0] blue;
    logic [7:0] orange;
    logic [7:0] infrared;
  } outcome_t;

  class gesture_light_tracker;
    logic [15:0] long_press;
    logic [15:0] ack_blink;
    logic        blue_held;
    logic        orange_held;
    logic [31:0] blue_start;
    logic [31:0] orange_start;
    logic        swallow_blue;
    logic        swallow_orange;
    outcome_t    due_outcomes[$];
    int unsigned failures;
    int unsigned results_seen;
    int unsigned swallowed;
    int unsigned event_tally[7];

    function new();
      long_press     = LONG_PRESS_RESET;
      ack_blink      = ACK_BLINK_RESET;
      blue_held      = 1'b0;
      orange_held    = 1'b0;
      blue_start     = '0;
      orange_start   = '0;
      swallow_blue   = 1'b0;
      swallow_orange = 1'b0;
      failures       = 0;
      results_seen   = 0;
      swallowed      = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_LONG_PRESS: long_press = data;
        REG_ACK_BLINK:  ack_blink = data;
        default: ;
      endcase
    endfunction

    // inside an acknowledge window after the press or after the long-press mark
    function bit blanked(logic [31:0] now, logic [31:0] start);
      logic [32:0] held_for;
      logic [32:0] lp;
      logic [32:0] bl;
      held_for = {1'b0, now - start};
      lp = {17'd0, long_press};
      bl = {17'd0, ack_blink};
      return (held_for < bl) || ((held_for < bl + lp) && (held_for > lp));
    endfunction

    function void note_request(request_t r);
      outcome_t   o;
      logic       blue_was;
      logic       orange_was;
      logic [7:0] def;
      o.ev = EV_NONE;
      o.blue = '0;
      o.orange = '0;
      o.infrared = '0;
      if (r.op == OP_STATUS) begin
        blue_was = blue_held;
        orange_was = orange_held;
        blue_held = !r.bits[BLUE_BIT];
        if (blue_held && !blue_was) blue_start = r.now;
        orange_held = !r.bits[ORANGE_BIT];
        if (orange_held && !orange_was) orange_start = r.now;
        if (!blue_held && blue_was) begin
          if (swallow_blue) begin
            swallow_blue = 1'b0;
            swallowed++;
          end else if (orange_held) begin
            swallow_orange = 1'b1;
            o.ev = EV_BLUE_DUO;
          end else begin
            o.ev = (r.now - blue_start < {16'd0, long_press}) ? EV_BLUE_SHORT : EV_BLUE_LONG;
          end
        end
        // an event from blue hides orange's release in the same request
        if (o.ev == EV_NONE && !orange_held && orange_was) begin
          if (swallow_orange) begin
            swallow_orange = 1'b0;
            swallowed++;
          end else if (blue_held) begin
            swallow_blue = 1'b1;
            o.ev = EV_ORANGE_DUO;
          end else begin
            o.ev = (r.now - orange_start < {16'd0, long_press}) ?
                   EV_ORANGE_SHORT : EV_ORANGE_LONG;
          end
        end
      end else begin
        def = r.conn ? r.bright : DEFAULT_LEVEL;
        o.blue = def;
        o.orange = def;
        if (r.duo > 0 || r.solo > 0) o.blue = '0;
        if (r.duo < 0 || r.solo < 0) o.orange = '0;
        if (orange_held) begin
          if (blanked(r.now, orange_start)) o.orange = '0;
          o.blue = '0;
        end
        if (blue_held) begin
          if (blanked(r.now, blue_start)) o.blue = '0;
          o.orange = '0;
        end
        // later press gets its light back, ties go to blue
        if (blue_held && orange_held) begin
          if (blue_start < orange_start) o.orange = def;
          else o.blue = def;
        end
        o.infrared = (r.duo <= IR_MODE_MAX) ? r.ir : 8'd0;
      end
      event_tally[o.ev]++;
      due_outcomes.push_back(o);
    endfunction

    function void check_result(logic [2:0] ev, logic [7:0] blue, logic [7:0] orange,
                               logic [7:0] infrared);
      outcome_t want;
      results_seen++;
      if (due_outcomes.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0d with nothing pending: event %0d blue %0d orange %0d ir %0d",
                   results_seen, ev, blue, orange, infrared);
        return;
      end
      want = due_outcomes.pop_front();
      if (ev !== want.ev || blue !== want.blue || orange !== want.orange ||
          infrared !== want.infrared) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0d: expected event %0d blue %0d orange %0d ir %0d, got %0d %0d %0d %0d",
                   results_seen, want.ev, want.blue, want.orange, want.infrared,
                   ev, blue, orange, infrared);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [31:0] now_ms = '0;
  logic [1:0] status_bits = 2'b11;
  logic connected = 1'b0;
  logic [7:0] brightness = '0;
  logic signed [7:0] duo_mode = '0;
  logic signed [7:0] solo_mode = '0;
  logic [7:0] infrared_request = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] event_code;
  logic [7:0] blue_level;
  logic [7:0] orange_level;
  logic [7:0] infrared_level;

  gesture_light_tracker tracker = new();
  bit quiet = 1'b0;
  logic [31:0] clock_ms = '0;
  int unsigned requests_sent = 0;
  int unsigned refreshes_sent = 0;

  button_gesture_and_ack_lights uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .now_ms(now_ms),
    .status_bits(status_bits),
    .connected(connected),
    .brightness(brightness),
    .duo_mode(duo_mode),
    .solo_mode(solo_mode),
    .infrared_request(infrared_request),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_code(event_code),
    .blue_level(blue_level),
    .orange_level(orange_level),
    .infrared_level(infrared_level)
  );

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("timed out with %0d results pending", tracker.due_outcomes.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [7:0] pick_mode();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'sd0;
      4: return -8'sd1;
      5: return IR_MODE_MAX;
      6: return 8'sd1;
      7: return -8'sd128;
      8: return 8'sd127;
      default: return 8'($urandom);
    endcase
  endfunction

  // time offsets clustered around the blink and long-press edges
  function automatic logic [31:0] pick_offset();
    logic [31:0] lp;
    logic [31:0] bl;
    lp = tracker.long_press;
    bl = tracker.ack_blink;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, bl + 2);
      3, 4: return (lp < 3) ? $urandom_range(0, lp + 3) : lp - 3 + $urandom_range(0, 6);
      5, 6: return lp + $urandom_range(0, bl + 2);
      7: return '0;
      8: return $urandom_range(0, lp + bl + 50);
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t status_req(logic [31:0] now, logic [1:0] bits);
    request_t r;
    r.op = OP_STATUS;
    r.now = now;
    r.bits = bits;
    r.conn = 1'($urandom);
    r.bright = 8'($urandom);
    r.duo = 8'($urandom);
    r.solo = 8'($urandom);
    r.ir = 8'($urandom);
    return r;
  endfunction

  function automatic request_t refresh_req(logic [31:0] now, logic conn, logic [7:0] bright,
                                           logic signed [7:0] duo, logic signed [7:0] solo,
                                           logic [7:0] ir);
    request_t r;
    r.op = OP_REFRESH;
    r.now = now;
    r.bits = 2'($urandom);
    r.conn = conn;
    r.bright = bright;
    r.duo = duo;
    r.solo = solo;
    r.ir = ir;
    return r;
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    in_valid <= 1'b1;
    operation <= r.op;
    now_ms <= r.now;
    status_bits <= r.bits;
    connected <= r.conn;
    brightness <= r.bright;
    duo_mode <= r.duo;
    solo_mode <= r.solo;
    infrared_request <= r.ir;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(r);
    requests_sent++;
    if (r.op == OP_REFRESH) refreshes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request();
    request_t r;
    logic [31:0] anchor;
    logic [1:0] held_bits;
    r = refresh_req($urandom, 1'($urandom), 8'($urandom), pick_mode(), pick_mode(),
                    8'($urandom));
    r.op = op_t'($urandom_range(0, 1));
    if ($urandom_range(0, 9) != 0) begin
      held_bits[BLUE_BIT] = !tracker.blue_held;
      held_bits[ORANGE_BIT] = !tracker.orange_held;
      anchor = clock_ms;
      if (tracker.blue_held && $urandom_range(0, 1)) anchor = tracker.blue_start;
      else if (tracker.orange_held && $urandom_range(0, 1)) anchor = tracker.orange_start;
      r.now = anchor + pick_offset();
      clock_ms = r.now;
      r.op = ($urandom_range(0, 9) < 6) ? OP_STATUS : OP_REFRESH;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r.bits = held_bits ^ (2'b01 << BLUE_BIT);
        4, 5, 6, 7: r.bits = held_bits ^ (2'b01 << ORANGE_BIT);
        8: r.bits = ~held_bits;
        default: r.bits = 2'($urandom);
      endcase
    end
    send_request(r);
  endtask

  task automatic program_timing(input logic [15:0] lp, input logic [15:0] bl);
    logic [1:0] spare;
    logic [15:0] junk;
    spare = 2'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG));
    junk = 16'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_LONG_PRESS;
    cfg_data <= lp;
    @(posedge clk);
    cfg_index <= REG_ACK_BLINK;
    cfg_data <= bl;
    @(posedge clk);
    // write to an index past the register list must change nothing
    cfg_index <= spare;
    cfg_data <= junk;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.write_register(REG_LONG_PRESS, lp);
    tracker.write_register(REG_ACK_BLINK, bl);
    tracker.write_register(spare, junk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (tracker.due_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin : ready_pattern
    int run_len;
    int stall_len;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result(event_code, blue_level, orange_level, infrared_level);
  end

  initial begin : stimulus
    logic [15:0] lp_plan [PHASES];
    logic [15:0] bl_plan [PHASES];
    lp_plan = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF, LONG_PRESS_RESET, 16'd0, 16'd0, 16'd0};
    bl_plan = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd1, ACK_BLINK_RESET, 16'd0, 16'd0, 16'd0};
    lp_plan[5] = 16'($urandom_range(1, 500));
    bl_plan[5] = 16'($urandom_range(1, 300));
    lp_plan[6] = 16'($urandom_range(1, 65535));
    bl_plan[6] = 16'($urandom_range(1, 65535));
    lp_plan[7] = 16'($urandom_range(20, 2000));
    bl_plan[7] = 16'($urandom_range(1, 200));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    program_timing(LONG_PRESS_RESET, ACK_BLINK_RESET);

    // level extremes and the infrared threshold
    send_request(refresh_req(32'd0, 1'b0, 8'd0, 8'sd0, 8'sd0, 8'hFF));
    send_request(refresh_req(32'd0, 1'b1, 8'hFF, IR_MODE_MAX, 8'sd0, 8'hA5));
    send_request(refresh_req(32'd0, 1'b1, 8'd0, 8'sd127, -8'sd128, 8'hFF));
    send_request(refresh_req(32'hFFFF_FFFF, 1'b1, 8'h5A, -8'sd128, 8'sd127, 8'h3C));
    // blue short press with refreshes inside and outside the blink windows
    send_request(status_req(32'd1000, 2'b10));
    send_request(refresh_req(32'd1050, 1'b1, 8'd200, 8'sd0, 8'sd0, 8'd0));
    send_request(refresh_req(32'd1500, 1'b1, 8'd200, 8'sd0, 8'sd0, 8'd0));
    send_request(refresh_req(32'd2050, 1'b1, 8'd200, -8'sd1, 8'sd0, 8'd0));
    send_request(status_req(32'd1999, 2'b11));
    // orange long press exactly at the mark
    send_request(status_req(32'd3000, 2'b01));
    send_request(status_req(32'd4000, 2'b11));
    // both pressed together, equal start times, both released together
    send_request(status_req(32'd5000, 2'b00));
    send_request(refresh_req(32'd5200, 1'b0, 8'd0, 8'sd0, 8'sd0, 8'd0));
    send_request(status_req(32'd5300, 2'b11));
    // blue released while orange held, orange release swallowed
    send_request(status_req(32'd6000, 2'b10));
    send_request(status_req(32'd6100, 2'b00));
    send_request(status_req(32'd6200, 2'b01));
    send_request(status_req(32'd6300, 2'b11));
    // orange gesture, then swallowed blue and examined orange in one request
    send_request(status_req(32'd7000, 2'b00));
    send_request(status_req(32'd7100, 2'b10));
    send_request(status_req(32'd7200, 2'b00));
    send_request(status_req(32'd7300, 2'b11));
    // time wrap, start order compared as raw values
    send_request(status_req(32'hFFFF_FFF0, 2'b10));
    send_request(status_req(32'd5, 2'b00));
    send_request(refresh_req(32'h20, 1'b1, 8'd77, 8'sd0, 8'sd0, 8'd0));
    send_request(status_req(32'h30, 2'b11));
    clock_ms = 32'h30;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_timing(lp_plan[p], bl_plan[p]);
      quiet = (p == 4);
      repeat (PHASE_ITEMS) random_request();
    end
    quiet = 1'b0;
    settle();

    $display("%0d requests (%0d light refreshes) over %0d timing settings, %0d results checked",
             requests_sent, refreshes_sent, PHASES + 1, tracker.results_seen);
    $display("presses: blue %0d short %0d long, orange %0d short %0d long, duo %0d/%0d, %0d swallowed",
             tracker.event_tally[EV_BLUE_SHORT], tracker.event_tally[EV_BLUE_LONG],
             tracker.event_tally[EV_ORANGE_SHORT], tracker.event_tally[EV_ORANGE_LONG],
             tracker.event_tally[EV_BLUE_DUO], tracker.event_tally[EV_ORANGE_DUO],
             tracker.swallowed);
    if (tracker.due_outcomes.size() != 0)
      $display("%0d expected results never arrived", tracker.due_outcomes.size());
    if (tracker.failures == 0 && tracker.due_outcomes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bgal_pkg.sv
rtl/bgal_gesture.sv
rtl/bgal_lights.sv
rtl/button_gesture_and_ack_lights.sv
tb/tb_top.sv
